[rtl/srr_pkg.sv]
// ----------------------------------------------------------------------------
// srr_pkg - shared types and constants for the symbol rate ratio set-up
// Widths, thresholds, coefficient bytes and the item record that travels
// down the pipeline.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int RATE_W      = 27;
  localparam int COEFF_W     = 8;
  localparam int RATIO_W     = 24;
  localparam int SAVED_W     = 6;
  localparam int DIV_W       = RATE_W - 4;            // master clock >> 4
  localparam int NUM_W       = 1 + RATE_W + 20;       // (rate << 4) << 16, padded
  localparam int DIGIT_W     = 4;                     // quotient bits per stage
  localparam int DIV_STAGES  = NUM_W / DIGIT_W;

  localparam logic [RATE_W-1:0] RATE_FLOOR   = RATE_W'(500000);
  localparam logic [RATE_W-1:0] THRESH_30M   = RATE_W'(30000000);
  localparam logic [RATE_W-1:0] THRESH_14M   = RATE_W'(14000000);
  localparam logic [RATE_W-1:0] THRESH_7M    = RATE_W'(7000000);
  localparam logic [RATE_W-1:0] THRESH_3M    = RATE_W'(3000000);
  localparam logic [RATE_W-1:0] THRESH_1M5   = RATE_W'(1500000);
  localparam logic [RATE_W-1:0] CLOCK_RESET  = RATE_W'(88000000);

  localparam logic [COEFF_W-1:0] ALPHA_FAST  = 8'hb4;
  localparam logic [COEFF_W-1:0] ALPHA_MID   = 8'hb6;
  localparam logic [COEFF_W-1:0] ALPHA_SLOW  = 8'hb7;
  localparam logic [COEFF_W-1:0] BETA_30M    = 8'h51;
  localparam logic [COEFF_W-1:0] BETA_7M     = 8'h53;
  localparam logic [COEFF_W-1:0] BETA_3M     = 8'h4f;
  localparam logic [COEFF_W-1:0] BETA_1M5    = 8'h4b;
  localparam logic [COEFF_W-1:0] BETA_LOW    = 8'h47;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [COEFF_W-1:0] alpha;
    logic [COEFF_W-1:0] beta;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [DIV_W-1:0]   rem;
    logic [RATIO_W-1:0] quo;
  } div_item_t;

  // Dividend of the ratio: clamped rate scaled by 16 and by two radix-256 digits.
  function automatic logic [NUM_W-1:0] dividend(input logic [RATE_W-1:0] rate);
    dividend = {1'b0, rate, 20'd0};
  endfunction

endpackage

[rtl/srr_front.sv]
// ----------------------------------------------------------------------------
// srr_front - clamp and coefficient stage
// Clamps the requested rate to the master clock, then to the floor, picks
// the loop coefficient bytes and seeds the divider state.
// ----------------------------------------------------------------------------
module srr_front
  import srr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RATE_W-1:0] symbol_rate,
  input  logic [RATE_W-1:0] master_clock_hz,
  output logic              out_valid,
  input  logic              out_ready,
  output div_item_t         out_item
);

  logic [RATE_W-1:0]  clamped;
  logic [COEFF_W-1:0] alpha;
  logic [COEFF_W-1:0] beta;
  logic               valid;
  div_item_t          item;

  // Ceiling first, floor second: the floor wins for a slow master clock.
  always_comb begin
    clamped = (symbol_rate > master_clock_hz) ? master_clock_hz : symbol_rate;
    if (clamped < RATE_FLOOR) begin
      clamped = RATE_FLOOR;
    end
  end

  always_comb begin
    priority if (clamped < THRESH_1M5) begin
      alpha = ALPHA_SLOW;
      beta  = BETA_LOW;
    end else if (clamped < THRESH_3M) begin
      alpha = ALPHA_SLOW;
      beta  = BETA_1M5;
    end else if (clamped < THRESH_7M) begin
      alpha = ALPHA_SLOW;
      beta  = BETA_3M;
    end else if (clamped < THRESH_14M) begin
      alpha = ALPHA_SLOW;
      beta  = BETA_7M;
    end else if (clamped < THRESH_30M) begin
      alpha = ALPHA_MID;
      beta  = BETA_7M;
    end else begin
      alpha = ALPHA_FAST;
      beta  = BETA_30M;
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.side.rate  <= clamped;
      item.side.alpha <= alpha;
      item.side.beta  <= beta;
      item.rem        <= '0;
      item.quo        <= '0;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

[rtl/srr_div_stage.sv]
// ----------------------------------------------------------------------------
// srr_div_stage - one stage of the restoring divider
// Retires one digit of quotient bits against the divisor and registers the
// partial remainder, the running quotient and the side fields.
// ----------------------------------------------------------------------------
module srr_div_stage
  import srr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  div_item_t          in_item,
  input  logic [DIGIT_W-1:0] digit,
  input  logic [DIV_W-1:0]   divisor,
  output logic               out_valid,
  input  logic               out_ready,
  output div_item_t          out_item
);

  logic [DIV_W-1:0]   rem_next;
  logic [DIGIT_W-1:0] qbits;
  logic               valid;
  div_item_t          item;

  always_comb begin
    logic [DIV_W:0] shifted;
    rem_next = in_item.rem;
    qbits    = '0;
    for (int k = 0; k < DIGIT_W; k++) begin
      shifted = {rem_next, digit[DIGIT_W-1-k]};
      if (shifted >= {1'b0, divisor}) begin
        shifted = shifted - {1'b0, divisor};
        qbits[DIGIT_W-1-k] = 1'b1;
      end
      rem_next = shifted[DIV_W-1:0];
    end
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.side <= in_item.side;
      item.rem  <= rem_next;
      // Drop quotient bits above the ratio width.
      item.quo  <= {in_item.quo[RATIO_W-DIGIT_W-1:0], qbits};
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

[rtl/symbol_rate_ratio_setup.sv]
// ----------------------------------------------------------------------------
// symbol_rate_ratio_setup - demodulator symbol rate set-up
// Clamps a requested symbol rate, picks the carrier loop coefficient bytes
// and computes the 24-bit symbol frequency ratio in a pipelined divider.
//
// Usage:
//   Input channel  : in_valid / in_ready with symbol_rate.
//   Output channel : out_valid / out_ready with clamped_rate, alpha_coeff,
//                    beta_coeff, rate_ratio and beta_saved; one result per
//                    input transfer, in order.
//   Configuration  : cfg_wr_en / cfg_wr_data write master_clock_hz;
//                    write it only while no item is in flight.
//   Pipeline       : one clamp/coefficient stage plus twelve divider stages.
//   Throughput     : one item per cycle while out_ready is high; each divider
//                    stage retires four quotient bits of the 48-bit dividend.
//   Reset          : rst (synchronous) empties the pipeline and sets the
//                    master clock to 88 MHz.
//   Stall          : when out_ready is low, full stages hold and bubbles
//                    close up; in_ready falls only when every stage is full.
// ----------------------------------------------------------------------------
module symbol_rate_ratio_setup
  import srr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [RATE_W-1:0]  cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [RATE_W-1:0]  symbol_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [RATE_W-1:0]  clamped_rate,
  output logic [COEFF_W-1:0] alpha_coeff,
  output logic [COEFF_W-1:0] beta_coeff,
  output logic [RATIO_W-1:0] rate_ratio,
  output logic [SAVED_W-1:0] beta_saved
);

  logic [RATE_W-1:0] master_clock_hz;
  logic [DIV_W-1:0]  divisor;

  // Stage handshakes: index 0 is the front stage, index s+1 is divider stage s.
  logic      stage_valid [DIV_STAGES+1];
  logic      stage_ready [DIV_STAGES+1];
  div_item_t stage_item  [DIV_STAGES+1];

  // Master clock register; the divider works on the clock divided by 16.
  always_ff @(posedge clk) begin
    if (rst) begin
      master_clock_hz <= CLOCK_RESET;
    end else if (cfg_wr_en) begin
      master_clock_hz <= cfg_wr_data;
    end
  end

  assign divisor = master_clock_hz[RATE_W-1:4];

  srr_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .symbol_rate     (symbol_rate),
    .master_clock_hz (master_clock_hz),
    .out_valid       (stage_valid[0]),
    .out_ready       (stage_ready[0]),
    .out_item        (stage_item[0])
  );

  // Each divider stage takes its own digit of the dividend, most significant
  // first. A zero divisor yields all-ones quotient bits, as the ratio needs.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic [NUM_W-1:0] num;

    assign num = dividend(stage_item[s].side.rate);

    srr_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[s]),
      .in_ready  (stage_ready[s]),
      .in_item   (stage_item[s]),
      .digit     (num[NUM_W-1-DIGIT_W*s -: DIGIT_W]),
      .divisor   (divisor),
      .out_valid (stage_valid[s+1]),
      .out_ready (stage_ready[s+1]),
      .out_item  (stage_item[s+1])
    );
  end

  // The last divider stage register is the output register.
  assign stage_ready[DIV_STAGES] = out_ready;
  assign out_valid    = stage_valid[DIV_STAGES];
  assign clamped_rate = stage_item[DIV_STAGES].side.rate;
  assign alpha_coeff  = stage_item[DIV_STAGES].side.alpha;
  assign beta_coeff   = stage_item[DIV_STAGES].side.beta;
  assign rate_ratio   = stage_item[DIV_STAGES].quo;
  assign beta_saved   = stage_item[DIV_STAGES].side.beta[SAVED_W-1:0];

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the symbol rate ratio set-up block
// Walks the master clock through a series of settings. Under each setting it
// sends corner and random symbol rates through the valid/ready input, with
// gaps and long back-pressure on the result side. Each result is compared
// field by field with a local prediction of the clamp, the coefficient
// bytes and the 24-bit ratio.
// ----------------------------------------------------------------------------
module tb;
  import srr_pkg::*;

  localparam int          PHASES           = 8;
  localparam int          RANDOM_PER_PHASE = 66;
  localparam int          HOLD_CYCLES      = 80;   // long receiver hold-off
  localparam int          DRAIN_CYCLES     = 20;   // pipeline is 13 deep
  localparam longint      RUN_LIMIT_NS     = 64'd10_000_000;
  localparam longint      RATE_MAX         = (64'd1 << RATE_W) - 1;

  // One expected result of the block
  typedef struct {
    logic [RATE_W-1:0]  rate;
    logic [COEFF_W-1:0] alpha;
    logic [COEFF_W-1:0] beta;
    logic [RATIO_W-1:0] ratio;
    logic [SAVED_W-1:0] saved;
  } rate_setup_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               cfg_wr_en    = 1'b0;
  logic [RATE_W-1:0]  cfg_wr_data  = '0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [RATE_W-1:0]  symbol_rate  = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [RATE_W-1:0]  clamped_rate;
  logic [COEFF_W-1:0] alpha_coeff;
  logic [COEFF_W-1:0] beta_coeff;
  logic [RATIO_W-1:0] rate_ratio;
  logic [SAVED_W-1:0] beta_saved;

  // Local copy of the master clock register
  logic [RATE_W-1:0]  master_clock = CLOCK_RESET;

  logic [RATE_W-1:0]  pending_rates[$];   // rates waiting to be offered
  rate_setup_t        setup_due[$];       // predictions awaiting their result

  int  mismatches  = 0;
  bit  src_steady  = 1'b0;                // sender offers back to back
  bit  snk_steady  = 1'b0;                // receiver always ready
  int  src_wait    = 0;
  int  snk_wait    = 0;
  int  hold_left   = 0;
  int  holds_asked = 0;
  int  holds_done  = 0;

  symbol_rate_ratio_setup dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .symbol_rate  (symbol_rate),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .clamped_rate (clamped_rate),
    .alpha_coeff  (alpha_coeff),
    .beta_coeff   (beta_coeff),
    .rate_ratio   (rate_ratio),
    .beta_saved   (beta_saved)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predict the result for one requested rate under a given master clock.
  function automatic rate_setup_t rate_setup_of(input logic [RATE_W-1:0] req,
                                                input logic [RATE_W-1:0] clock);
    rate_setup_t       r;
    logic [RATE_W-1:0] rate;
    logic [63:0]       divisor;
    logic [63:0]       quo;
    // Ceiling first, floor second: a clock below the floor still gives the floor
    rate = (req > clock) ? clock : req;
    if (rate < RATE_FLOOR) rate = RATE_FLOOR;
    r.rate = rate;
    if (rate >= THRESH_30M) begin
      r.alpha = ALPHA_FAST;
      r.beta  = BETA_30M;
    end else if (rate >= THRESH_14M) begin
      r.alpha = ALPHA_MID;
      r.beta  = BETA_7M;
    end else if (rate >= THRESH_7M) begin
      r.alpha = ALPHA_SLOW;
      r.beta  = BETA_7M;
    end else if (rate >= THRESH_3M) begin
      r.alpha = ALPHA_SLOW;
      r.beta  = BETA_3M;
    end else if (rate >= THRESH_1M5) begin
      r.alpha = ALPHA_SLOW;
      r.beta  = BETA_1M5;
    end else begin
      r.alpha = ALPHA_SLOW;
      r.beta  = BETA_LOW;
    end
    // Three radix-256 digits of (rate * 16) / (clock >> 4) are exactly the
    // floor of (rate << 20) / (clock >> 4); keep the low 24 bits, so a rate
    // equal to a clock that is a multiple of 16 wraps to zero.
    divisor = 64'(clock >> 4);
    if (divisor == 0) begin
      r.ratio = '1;                       // a bare divider answers all ones
    end else begin
      quo     = (64'(rate) << 20) / divisor;
      r.ratio = quo[RATIO_W-1:0];
    end
    r.saved = r.beta[SAVED_W-1:0];
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int next_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Random rate: around the clock range, near a threshold, at the clock, or any
  // 27-bit value.
  function automatic logic [RATE_W-1:0] draw_rate(input logic [RATE_W-1:0] clock);
    longint            v;
    int                pick;
    logic [RATE_W-1:0] marks[6];
    marks = '{RATE_FLOOR, THRESH_1M5, THRESH_3M, THRESH_7M, THRESH_14M, THRESH_30M};
    pick  = $urandom_range(0, 9);
    if (pick < 5)
      v = longint'($urandom_range(0, clock));
    else if (pick < 7)
      v = longint'(marks[$urandom_range(0, 5)]) + longint'($urandom_range(0, 6)) - 3;
    else if (pick == 7)
      v = longint'(clock) + longint'($urandom_range(0, 4)) - 2;
    else
      v = longint'($urandom_range(0, RATE_MAX));
    if (v < 0) v = 0;
    if (v > RATE_MAX) v = RATE_MAX;
    return v[RATE_W-1:0];
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, field, want, want, got, got);
    end
  endtask

  // Return at a falling edge once nothing is queued, offered or outstanding.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_rates.size() != 0 || in_valid || setup_due.size() != 0);
  endtask

  // Write the master clock while the pipeline is empty; track it locally.
  task automatic write_master_clock(input logic [RATE_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    master_clock <= value;
  endtask

  // Driver: predict each accepted rate, then offer the next one after its gap.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_wait <= 0;
    end else begin
      if (in_valid && in_ready)
        setup_due.push_back(rate_setup_of(symbol_rate, master_clock));
      // Hold valid and payload until the transfer; otherwise the slot is free
      if (!in_valid || in_ready) begin
        if (src_wait > 0) begin
          in_valid <= 1'b0;
          src_wait <= src_wait - 1;
        end else if (pending_rates.size() != 0) begin
          in_valid    <= 1'b1;
          symbol_rate <= pending_rates.pop_front();
          src_wait    <= src_steady ? 0 : next_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer and pace out_ready, including the
  // long hold-off that lets the pipeline fill and stall its input.
  always @(posedge clk) begin : monitor
    rate_setup_t want;
    int          gap;
    if (rst) begin
      out_ready <= 1'b0;
      snk_wait  <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (setup_due.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected, actual rate %0d ratio 0x%0h",
                   $time, clamped_rate, rate_ratio);
        end else begin
          want = setup_due.pop_front();
          check_field("clamped_rate", 32'(want.rate),  32'(clamped_rate));
          check_field("alpha_coeff",  32'(want.alpha), 32'(alpha_coeff));
          check_field("beta_coeff",   32'(want.beta),  32'(beta_coeff));
          check_field("rate_ratio",   32'(want.ratio), 32'(rate_ratio));
          check_field("beta_saved",   32'(want.saved), 32'(beta_saved));
        end
      end
      if (holds_done != holds_asked) begin
        holds_done <= holds_done + 1;
        hold_left  <= HOLD_CYCLES;
        out_ready  <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait  <= snk_wait - 1;
        out_ready <= 1'b0;
      end else if (snk_steady) begin
        out_ready <= 1'b1;
      end else begin
        gap = next_gap();
        out_ready <= (gap == 0);
        snk_wait  <= (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  // Stimulus: one phase per master clock setting, each drained before the
  // next write.
  initial begin : stimulus
    logic [RATE_W-1:0] clocks[PHASES];
    logic [RATE_W-1:0] corners[$];
    // Reset value, top of range, bottom of range, below the floor, zero
    // divisor, divisor of one, a multiple of 16, and one drawn at random
    clocks = '{CLOCK_RESET, RATE_W'(RATE_MAX), RATE_W'(1000000), RATE_W'(300000),
               RATE_W'(15), RATE_W'(16), RATE_W'(48000000),
               RATE_W'($urandom_range(1000000, RATE_MAX))};
    // Field extremes, floor and every threshold from both sides, and a rate
    // equal to the reset clock (ratio wraps to zero)
    corners = '{RATE_W'(0), RATE_W'(RATE_MAX), RATE_FLOOR - 1, RATE_FLOOR,
                THRESH_1M5 - 1, THRESH_1M5, THRESH_3M - 1, THRESH_3M,
                THRESH_7M - 1, THRESH_7M, THRESH_14M - 1, THRESH_14M,
                THRESH_30M - 1, THRESH_30M, CLOCK_RESET, CLOCK_RESET + 1};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      // Sender pauses here until every result of the last phase is in
      wait_drained();
      if (p > 0) write_master_clock(clocks[p]);
      @(negedge clk);
      src_steady = (p % 3 == 1);
      snk_steady = (p % 4 == 2);
      if (p == 0)
        foreach (corners[i]) pending_rates.push_back(corners[i]);
      pending_rates.push_back(clocks[p]);
      pending_rates.push_back(clocks[p] + 1);
      pending_rates.push_back(clocks[p] - 1);
      repeat (RANDOM_PER_PHASE) pending_rates.push_back(draw_rate(clocks[p]));
      // Stall the receiver while a steady sender keeps offering
      if (p == 1 || p == 4) holds_asked++;
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
